// ===== design/mrsp_pkg.sv =====
// Package with the shared types, constants and helper functions of the mask run segment plotter.
`timescale 1ns / 1ps
package mrsp_pkg;

	localparam int COORD_BITS  = 16;
	localparam int FRAC_BITS   = 8;
	localparam int ACC_BITS    = COORD_BITS + FRAC_BITS;
	localparam int CNT_BITS    = 12;
	localparam int DIM_BITS    = 13;
	localparam int MAX_COLUMNS = 4096;
	localparam int MAX_ROWS    = 4096;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int CMD_SLOTS     = 4;
	localparam int SLOT_BITS     = $clog2(CMD_SLOTS);

	localparam logic [COORD_BITS-1:0] MAP_WIDTH_RST = COORD_BITS'(720);
	localparam logic [ACC_BITS-1:0]   X_STEP_RST    = ACC_BITS'(512);
	localparam logic [ACC_BITS-1:0]   Y_STEP_RST    = ACC_BITS'(512);
	localparam logic [COORD_BITS-1:0] X_OFFSET_RST  = '0;
	localparam logic [DIM_BITS-1:0]   COLUMNS_RST   = DIM_BITS'(360);
	localparam logic [DIM_BITS-1:0]   ROWS_RST      = DIM_BITS'(180);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MAP_WIDTH = 3'd0,
		CFG_X_STEP    = 3'd1,
		CFG_Y_STEP    = 3'd2,
		CFG_X_OFFSET  = 3'd3,
		CFG_COLUMNS   = 3'd4,
		CFG_ROWS      = 3'd5,
		CFG_PLOT_SEA  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] map_width;
		logic [ACC_BITS-1:0]   x_step;
		logic [ACC_BITS-1:0]   y_step;
		logic [COORD_BITS-1:0] x_offset;
		logic [DIM_BITS-1:0]   columns;
		logic [DIM_BITS-1:0]   rows;
		logic                  plot_sea;
	} cfg_regs_t;

	// One closed run: plotter x of its first pixel and of its end, and the row y.
	typedef struct packed {
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] y;
	} seg_t;

	function automatic logic [ACC_BITS-1:0] sat_acc(input logic [ACC_BITS-1:0] a,
			input logic [ACC_BITS-1:0] b);
		logic [ACC_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
	endfunction

	// Clamp a signed coordinate to the unsigned output range.
	function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [COORD_BITS+1:0] v);
		logic [COORD_BITS-1:0] r;
		if (v[COORD_BITS+1])
			r = '0;
		else if (v[COORD_BITS])
			r = {COORD_BITS{1'b1}};
		else
			r = v[COORD_BITS-1:0];
		return r;
	endfunction

endpackage

// ===== design/mrsp_ifs.sv =====
// Valid/ready channel interfaces for pixels, plotter commands and configuration writes.
`timescale 1ns / 1ps
interface mrsp_pix_if;
	logic valid;
	logic ready;
	logic is_land;
	modport source (output valid, output is_land, input ready);
	modport sink (input valid, input is_land, output ready);
endinterface

interface mrsp_cmd_if;
	import mrsp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pen_x;
	logic [COORD_BITS-1:0] pen_y;
	logic                  pen_down;
	logic                  last_command;
	modport source (output valid, output pen_x, output pen_y, output pen_down,
		output last_command, input ready);
	modport sink (input valid, input pen_x, input pen_y, input pen_down,
		input last_command, output ready);
endinterface

interface mrsp_cfg_if;
	import mrsp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/mask_run_segment_plotter_unit.sv =====
// Top level of the mask run segment plotter: configuration registers, front end, queue, back end.
//
//  Channel  Dir  Beat payload                              Accepted when
//  pixel    in   is_land                                   valid && ready
//  command  out  pen_x, pen_y, pen_down, last_command      valid && ready
//  cfg      in   index (register number), data             valid && ready
//
// A pixel is taken every cycle while the four-entry segment queue has room.
// A closed run leaves as two or four commands from the output register, one per cycle while
// command ready is high, so the back end sets the rate once segments average more than one
// command per pixel: a split segment every other pixel gives two commands per pixel, and in a
// one-column frame a split run closed by every pixel gives four.
// Reset clears the counters, the open run and the queue; cfg is always ready.
// A stalled command channel fills the queue and then holds pixel ready low.
`timescale 1ns / 1ps
module mask_run_segment_plotter_unit (
	input  logic        clk,
	input  logic        arst_n,
	mrsp_pix_if.sink    pixel,
	mrsp_cmd_if.source  command,
	mrsp_cfg_if.sink    cfg
);
	import mrsp_pkg::*;

	cfg_regs_t cfg_q;
	logic      fifo_full, push, pop, head_valid;
	seg_t      push_seg, head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_width <= MAP_WIDTH_RST;
			cfg_q.x_step    <= X_STEP_RST;
			cfg_q.y_step    <= Y_STEP_RST;
			cfg_q.x_offset  <= X_OFFSET_RST;
			cfg_q.columns   <= COLUMNS_RST;
			cfg_q.rows      <= ROWS_RST;
			cfg_q.plot_sea  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MAP_WIDTH: cfg_q.map_width <= cfg.data[COORD_BITS-1:0];
				CFG_X_STEP:    cfg_q.x_step    <= cfg.data[ACC_BITS-1:0];
				CFG_Y_STEP:    cfg_q.y_step    <= cfg.data[ACC_BITS-1:0];
				CFG_X_OFFSET:  cfg_q.x_offset  <= cfg.data[COORD_BITS-1:0];
				CFG_COLUMNS:   cfg_q.columns   <= cfg.data[DIM_BITS-1:0];
				CFG_ROWS:      cfg_q.rows      <= cfg.data[DIM_BITS-1:0];
				CFG_PLOT_SEA:  cfg_q.plot_sea  <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	mrsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pixel.valid),
		.pix_ready (pixel.ready),
		.is_land   (pixel.is_land),
		.fifo_full (fifo_full),
		.push      (push),
		.seg       (push_seg)
	);

	mrsp_seg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_seg     (push_seg),
		.full       (fifo_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mrsp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.cmd_valid    (command.valid),
		.cmd_ready    (command.ready),
		.pen_x        (command.pen_x),
		.pen_y        (command.pen_y),
		.pen_down     (command.pen_down),
		.last_command (command.last_command)
	);

endmodule

// ===== design/mrsp_front.sv =====
// Front end: counts columns and rows, tracks the open run and emits closed segments.
`timescale 1ns / 1ps
module mrsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  mrsp_pkg::cfg_regs_t cfg,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  logic                is_land,
	input  logic                fifo_full,
	output logic                push,
	output mrsp_pkg::seg_t      seg
);
	import mrsp_pkg::*;

	logic [CNT_BITS-1:0]   col_q, row_q;
	logic [ACC_BITS-1:0]   x_acc_q, y_acc_q;
	logic                  run_open_q;
	logic [COORD_BITS-1:0] run_start_q;

	logic [DIM_BITS-1:0]   cols_c, rows_c, col_inc, row_inc;
	logic [COORD_BITS-1:0] x_cur, y_cur;
	logic                  accept, target, row_end, frame_end, emit;

	always_comb begin
		if (cfg.columns == '0)
			cols_c = DIM_BITS'(1);
		else if (cfg.columns > DIM_BITS'(MAX_COLUMNS))
			cols_c = DIM_BITS'(MAX_COLUMNS);
		else
			cols_c = cfg.columns;
		if (cfg.rows == '0)
			rows_c = DIM_BITS'(1);
		else if (cfg.rows > DIM_BITS'(MAX_ROWS))
			rows_c = DIM_BITS'(MAX_ROWS);
		else
			rows_c = cfg.rows;
	end

	assign pix_ready = !fifo_full;
	assign accept    = pix_valid && pix_ready;
	assign x_cur     = x_acc_q[ACC_BITS-1 -: COORD_BITS];
	assign y_cur     = y_acc_q[ACC_BITS-1 -: COORD_BITS];
	assign target    = is_land ^ cfg.plot_sea;
	assign col_inc   = {1'b0, col_q} + DIM_BITS'(1);
	assign row_inc   = {1'b0, row_q} + DIM_BITS'(1);
	assign row_end   = col_inc >= cols_c;
	assign frame_end = row_inc >= rows_c;

	// A run closes on a non-target pixel, or at the row end if it is open or opens here.
	assign emit = (!target && run_open_q) || (row_end && (run_open_q || target));
	assign push = accept && emit;

	always_comb begin
		seg.start_x = run_open_q ? run_start_q : x_cur;
		seg.end_x   = x_cur;
		seg.y       = y_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			x_acc_q     <= '0;
			y_acc_q     <= Y_STEP_RST;
			run_open_q  <= 1'b0;
			run_start_q <= '0;
		end else if (accept) begin
			run_open_q <= target && !row_end;
			if (target && !run_open_q)
				run_start_q <= x_cur;
			if (row_end) begin
				col_q   <= '0;
				x_acc_q <= '0;
				if (frame_end) begin
					row_q   <= '0;
					y_acc_q <= cfg.y_step;
				end else begin
					row_q   <= row_inc[CNT_BITS-1:0];
					y_acc_q <= sat_acc(y_acc_q, cfg.y_step);
				end
			end else begin
				col_q   <= col_inc[CNT_BITS-1:0];
				x_acc_q <= sat_acc(x_acc_q, cfg.x_step);
			end
		end
	end

endmodule

// ===== design/mrsp_seg_fifo.sv =====
// Short segment queue between the front end and the command back end.
`timescale 1ns / 1ps
module mrsp_seg_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrsp_pkg::seg_t wr_seg,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output mrsp_pkg::seg_t head
);
	import mrsp_pkg::*;

	seg_t                   mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_BITS:0]   count_q;

	assign full       = count_q == (FIFO_PTR_BITS+1)'(FIFO_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_seg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
			if (push && !pop)
				count_q <= count_q + (FIFO_PTR_BITS+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (FIFO_PTR_BITS+1)'(1);
		end
	end

endmodule

// ===== design/mrsp_back.sv =====
// Back end: offsets and wraps one segment and issues its pen moves and draws one per cycle while ready.
`timescale 1ns / 1ps
module mrsp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mrsp_pkg::cfg_regs_t   cfg,
	input  logic                  head_valid,
	input  mrsp_pkg::seg_t        head,
	output logic                  pop,
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output logic [mrsp_pkg::COORD_BITS-1:0] pen_x,
	output logic [mrsp_pkg::COORD_BITS-1:0] pen_y,
	output logic                  pen_down,
	output logic                  last_command
);
	import mrsp_pkg::*;

	typedef logic signed [COORD_BITS+1:0] wide_t;

	// Segment being issued.
	logic                  seg_valid_s1;
	logic [COORD_BITS-1:0] seg_x_s1 [CMD_SLOTS];
	logic [COORD_BITS-1:0] seg_y_s1;
	logic                  seg_four_s1;
	logic [SLOT_BITS-1:0]  slot_q;

	// Output register.
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic                  out_down_q, out_last_q;

	wide_t                 d1, d2, w, d1w, d2w;
	logic                  le1, neg2, le2, four_c, out_load, at_last;
	logic [COORD_BITS-1:0] x_c [CMD_SLOTS];

	always_comb begin
		w    = wide_t'({2'b00, cfg.map_width});
		d1   = wide_t'({2'b00, head.start_x}) - wide_t'({2'b00, cfg.x_offset});
		d2   = wide_t'({2'b00, head.end_x}) - wide_t'({2'b00, cfg.x_offset});
		d1w  = d1 + w;
		d2w  = d2 + w;
		le1  = d1[COORD_BITS+1] || (d1 == '0);
		neg2 = d2[COORD_BITS+1];
		le2  = neg2 || (d2 == '0);
		priority if (le1 && neg2) begin
			four_c = 1'b0;
			x_c[0] = clamp_coord(d1w);
			x_c[1] = clamp_coord(d2w);
			x_c[2] = '0;
			x_c[3] = '0;
		end else if (le1) begin
			// The segment straddles the seam: draw up to its end, then from its wrapped start.
			four_c = 1'b1;
			x_c[0] = '0;
			x_c[1] = clamp_coord(d2);
			x_c[2] = clamp_coord(d1w);
			x_c[3] = cfg.map_width;
		end else if (!le2) begin
			four_c = 1'b0;
			x_c[0] = clamp_coord(d1);
			x_c[1] = clamp_coord(d2);
			x_c[2] = '0;
			x_c[3] = '0;
		end else begin
			four_c = 1'b1;
			x_c[0] = '0;
			x_c[1] = clamp_coord(d1);
			x_c[2] = clamp_coord(d2w);
			x_c[3] = cfg.map_width;
		end
	end

	assign at_last  = seg_four_s1 ? (slot_q == SLOT_BITS'(CMD_SLOTS - 1)) : (slot_q == SLOT_BITS'(1));
	assign out_load = seg_valid_s1 && (!out_valid_q || cmd_ready);
	assign pop      = head_valid && (!seg_valid_s1 || (out_load && at_last));

	always_ff @(posedge clk) begin
		if (pop) begin
			seg_x_s1    <= x_c;
			seg_y_s1    <= head.y;
			seg_four_s1 <= four_c;
		end
		if (out_load) begin
			out_x_q    <= seg_x_s1[slot_q];
			out_y_q    <= seg_y_s1;
			out_down_q <= slot_q[0];
			out_last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid_s1 <= 1'b0;
			slot_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				seg_valid_s1 <= 1'b1;
				slot_q       <= '0;
			end else if (out_load) begin
				if (at_last)
					seg_valid_s1 <= 1'b0;
				slot_q <= slot_q + SLOT_BITS'(1);
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (cmd_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign cmd_valid    = out_valid_q;
	assign pen_x        = out_x_q;
	assign pen_y        = out_y_q;
	assign pen_down     = out_down_q;
	assign last_command = out_last_q;

endmodule

// ===== design/mrsp_checker.sv =====
// Port-level checker for the mask run segment plotter, bound to the top level.
`timescale 1ns / 1ps
module mrsp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic [mrsp_pkg::COORD_BITS-1:0] pen_x,
	input logic [mrsp_pkg::COORD_BITS-1:0] pen_y,
	input logic                          pen_down,
	input logic                          last_command
);
	import mrsp_pkg::*;

	// A pen-up move never ends the commands of a segment.
	a_move_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !pen_down |-> !last_command)
		else $error("move beat flagged as last command");

	// Every accepted move is followed at once by its draw.
	a_draw_follows_move: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !pen_down |=> cmd_valid && pen_down)
		else $error("move beat not followed by a draw");

	// The first pair of a split segment is followed at once by the second move.
	a_split_continues: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && pen_down && !last_command |=> cmd_valid && !pen_down)
		else $error("split segment lost its second pair");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(pen_x) && $stable(pen_y)
			&& $stable(pen_down) && $stable(last_command))
		else $error("command beat changed while stalled");

endmodule

bind mask_run_segment_plotter_unit mrsp_checker u_mrsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (command.valid),
	.cmd_ready    (command.ready),
	.pen_x        (command.pen_x),
	.pen_y        (command.pen_y),
	.pen_down     (command.pen_down),
	.last_command (command.last_command)
);
